### design/sprite_rle_frame_decoder_unit_macros.svh
// Assertion macros for the sprite RLE frame decoder.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SPRITE_RLE_FRAME_DECODER_UNIT_MACROS_SVH
`define SPRITE_RLE_FRAME_DECODER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked at every rising clock edge out of reset
`define SRFD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srfd assertion failed");
// next-cycle implication
`define SRFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srfd assertion failed");
`else
`define SRFD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SRFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### design/srfd_pkg.sv
// Shared types and constants for the sprite RLE frame decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package srfd_pkg;

   // field and state widths
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned RUN_W   = 7;
   localparam int unsigned SIDE_W  = 10;
   localparam int unsigned POS_W   = 11;
   localparam int unsigned ADDR_W  = 18;
   localparam int unsigned CSR_AW  = 4;
   localparam int unsigned CSR_DW  = 32;

   // stream codes
   localparam logic [BYTE_W-1:0] ROW_END_CODE = 8'h80;
   localparam logic [RUN_W-1:0]  RUN_MASK     = 7'h7F;
   localparam logic [POS_W-1:0]  POS_MAX      = 11'h7FF;

   // register indexes (byte address bits [3:2])
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_TOP_DOWN     = 2'd2;

   // register reset values
   localparam logic [SIDE_W-1:0] FRAME_WIDTH_RST  = 10'd256;
   localparam logic [SIDE_W-1:0] FRAME_HEIGHT_RST = 10'd256;
   localparam logic              TOP_DOWN_RST     = 1'b0;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } req_item_type;

   typedef struct packed {
      logic [ADDR_W-1:0] pixel_address;
      logic [BYTE_W-1:0] pixel_value;
   } rsp_item_type;

   typedef struct packed {
      logic [SIDE_W-1:0] frame_width;
      logic [SIDE_W-1:0] frame_height;
      logic              top_down;
   } cfg_type;

endpackage

`default_nettype wire

### design/sprite_rle_frame_decoder_unit.sv
// Sprite RLE frame decoder.
//
// req channel: one encoded byte of a sprite frame per request (data_byte),
//   with last_byte marking the final byte of the frame; the next request
//   starts a new frame. rsp channel: zero or one pixel write per request,
//   pixel_address = row * width + column (18 bits) and pixel_value.
// csr port: APB-style, frame_width at 0x0, frame_height at 0x4, top_down
//   at 0x8; pready is always high. Write registers only while idle.
// Pipeline: an accepted request is held in the input register and is decoded
//   into the result register once that register is free or being emptied;
//   the pixel is presented from the result register. Throughput is one
//   request per cycle while no result is held back by a low rsp_ready, set
//   by the combinational state update and row*width multiply.
// Stalls: while rsp_ready is low and a result is held, the input register
//   keeps one request and req_ready drops once it is full; requests that
//   produce no pixel also wait behind a held result to keep ordering.
// Reset: registers return to width 256, height 256, bottom-up; the decoder
//   awaits the first byte of a frame. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "sprite_rle_frame_decoder_unit_macros.svh"

module sprite_rle_frame_decoder_unit #(
   parameter int unsigned MAX_SIDE = 512
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire srfd_pkg::req_item_type        req_item,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output srfd_pkg::rsp_item_type             rsp_item,
   // configuration
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [srfd_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [srfd_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic      [srfd_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                               csr_pready
);
   import srfd_pkg::*;

   cfg_type      cfg;
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   logic         fire;
   logic         emit;
   rsp_item_type pixel;

   srfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // decode advances when the result slot is free or being emptied
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   srfd_core #(.MAX_SIDE(MAX_SIDE)) u_core (
      .clock (clock),
      .reset (reset),
      .step  (fire),
      .item  (in_item_ff),
      .cfg   (cfg),
      .emit  (emit),
      .pixel (pixel)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_item_ff <= pixel;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // checks
   `SRFD_ASSERT_IMPLIES(a_ready_low_only_when_blocked, clock, reset,
      !req_ready, in_valid_ff && rsp_valid_ff && !rsp_ready)
   `SRFD_ASSERT_IMPLIES(a_free_slot_decodes, clock, reset,
      in_valid_ff && !rsp_valid_ff, fire)
   `SRFD_ASSERT_NEXT(a_blocked_request_held, clock, reset,
      in_valid_ff && !fire, in_valid_ff)

endmodule

`default_nettype wire

### design/srfd_csr.sv
// APB-style configuration registers: frame width, frame height, row direction.
// Depends on srfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srfd_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [srfd_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [srfd_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic      [srfd_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                               csr_pready,
   output srfd_pkg::cfg_type                  cfg
);
   import srfd_pkg::*;

   logic [SIDE_W-1:0] frame_width_ff;
   logic [SIDE_W-1:0] frame_height_ff;
   logic              top_down_ff;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   // register writes in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         top_down_ff     <= TOP_DOWN_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_pwdata[SIDE_W-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_pwdata[SIDE_W-1:0];
            REG_TOP_DOWN:     top_down_ff     <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_FRAME_WIDTH:  csr_prdata = {{(CSR_DW-SIDE_W){1'b0}}, frame_width_ff};
         REG_FRAME_HEIGHT: csr_prdata = {{(CSR_DW-SIDE_W){1'b0}}, frame_height_ff};
         REG_TOP_DOWN:     csr_prdata = {{(CSR_DW-1){1'b0}}, top_down_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.frame_width  = frame_width_ff;
   assign cfg.frame_height = frame_height_ff;
   assign cfg.top_down     = top_down_ff;

endmodule

`default_nettype wire

### design/srfd_core.sv
// Decode state (column, row, literal count, frame start) and the per-byte step.
// Produces the pixel write for a literal byte. Depends on srfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srfd_core #(
   parameter int unsigned MAX_SIDE = 512
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire srfd_pkg::req_item_type item,
   input  wire srfd_pkg::cfg_type    cfg,
   output logic                      emit,
   output srfd_pkg::rsp_item_type    pixel
);
   import srfd_pkg::*;

   // side limit as seen by a 10-bit register
   localparam logic [SIDE_W-1:0] SIDE_CAP =
      (MAX_SIDE > 1023) ? 10'd1023 : MAX_SIDE[SIDE_W-1:0];

   logic [POS_W-1:0]        column_ff, column_in;
   logic [POS_W-1:0]        row_ff, row_in;
   logic [RUN_W-1:0]        literal_left_ff, literal_left_in;
   logic                    awaiting_ff, awaiting_in;

   logic [SIDE_W-1:0]       w;
   logic [SIDE_W-1:0]       h;
   logic [POS_W-1:0]        start_row;
   logic [POS_W-1:0]        col0;
   logic [POS_W-1:0]        row0;
   logic [RUN_W-1:0]        lit0;
   logic                    in_frame;
   logic [POS_W+SIDE_W-1:0] product;
   logic [POS_W+SIDE_W-1:0] addr_sum;

   // saturating add on column/row positions
   function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                input logic [RUN_W-1:0] b);
      logic [POS_W:0] s;
      s = {1'b0, a} + {{(POS_W+1-RUN_W){1'b0}}, b};
      return s[POS_W] ? POS_MAX : s[POS_W-1:0];
   endfunction

   // effective frame size
   assign w = (cfg.frame_width  > SIDE_CAP) ? SIDE_CAP : cfg.frame_width;
   assign h = (cfg.frame_height > SIDE_CAP) ? SIDE_CAP : cfg.frame_height;

   // first byte of a frame places the row and clears the run
   assign start_row = cfg.top_down ? '0 :
                      (h == '0) ? POS_MAX : {1'b0, h - 10'd1};
   assign col0 = awaiting_ff ? '0 : column_ff;
   assign row0 = awaiting_ff ? start_row : row_ff;
   assign lit0 = awaiting_ff ? '0 : literal_left_ff;

   // pixel address and bounds
   assign in_frame = (col0 < {1'b0, w}) && (row0 < {1'b0, h});
   assign product  = row0 * w;
   assign addr_sum = product + {{SIDE_W{1'b0}}, col0};

   assign emit                = step && (lit0 != '0) && in_frame;
   assign pixel.pixel_address = addr_sum[ADDR_W-1:0];
   assign pixel.pixel_value   = item.data_byte;

   // next state for one byte
   always_comb begin
      column_in       = col0;
      row_in          = row0;
      literal_left_in = lit0;
      awaiting_in     = item.last_byte;
      if (lit0 != '0) begin
         column_in       = sat_add(col0, 7'd1);
         literal_left_in = lit0 - 7'd1;
      end else if (item.data_byte == ROW_END_CODE) begin
         column_in = '0;
         if (cfg.top_down) begin
            row_in = sat_add(row0, 7'd1);
         end else if (row0 == '0 || row0 == POS_MAX) begin
            row_in = POS_MAX;
         end else begin
            row_in = row0 - 11'd1;
         end
      end else if (item.data_byte[BYTE_W-1]) begin
         column_in = sat_add(col0, item.data_byte[RUN_W-1:0] & RUN_MASK);
      end else begin
         literal_left_in = item.data_byte[RUN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff       <= '0;
         row_ff          <= '0;
         literal_left_ff <= '0;
         awaiting_ff     <= 1'b1;
      end else if (step) begin
         column_ff       <= column_in;
         row_ff          <= row_in;
         literal_left_ff <= literal_left_in;
         awaiting_ff     <= awaiting_in;
      end
   end

endmodule

`default_nettype wire
